[src/rrc_pkg.sv]
`default_nettype none

package rrc_pkg;

    localparam int COORD_W  = 24;
    localparam int RADIUS_W = 23;
    localparam int GEO_W    = 27;
    localparam int SQ_W     = 2 * GEO_W;
    localparam int SUM_W    = SQ_W + 1;
    localparam int INDEX_W  = 3;
    localparam int CORNERS  = 4;

    localparam logic [INDEX_W-1:0] REG_EDGE_LEFT           = 3'd0;
    localparam logic [INDEX_W-1:0] REG_EDGE_RIGHT          = 3'd1;
    localparam logic [INDEX_W-1:0] REG_EDGE_BOTTOM         = 3'd2;
    localparam logic [INDEX_W-1:0] REG_EDGE_TOP            = 3'd3;
    localparam logic [INDEX_W-1:0] REG_RADIUS_RIGHT_BOTTOM = 3'd4;
    localparam logic [INDEX_W-1:0] REG_RADIUS_RIGHT_TOP    = 3'd5;
    localparam logic [INDEX_W-1:0] REG_RADIUS_LEFT_TOP     = 3'd6;
    localparam logic [INDEX_W-1:0] REG_RADIUS_LEFT_BOTTOM  = 3'd7;

    localparam int CORNER_RB = 0;
    localparam int CORNER_RT = 1;
    localparam int CORNER_LT = 2;
    localparam int CORNER_LB = 3;

    localparam logic signed [COORD_W-1:0] EDGE_LEFT_RESET   = -24'sd25600;
    localparam logic signed [COORD_W-1:0] EDGE_RIGHT_RESET  = 24'sd25600;
    localparam logic signed [COORD_W-1:0] EDGE_BOTTOM_RESET = -24'sd25600;
    localparam logic signed [COORD_W-1:0] EDGE_TOP_RESET    = 24'sd25600;

    typedef struct packed {
        logic signed [COORD_W-1:0]          edge_left;
        logic signed [COORD_W-1:0]          edge_right;
        logic signed [COORD_W-1:0]          edge_bottom;
        logic signed [COORD_W-1:0]          edge_top;
        logic [CORNERS-1:0][RADIUS_W-1:0]   radius;
    } cfg_t;

    typedef struct packed {
        logic                    valid;
        logic                    outside;
        logic                    skip_circle;
        logic signed [GEO_W-1:0] dx;
        logic signed [GEO_W-1:0] dy;
        logic signed [GEO_W-1:0] r;
    } corner_t;

endpackage

`default_nettype wire

[src/rrc_cfg.sv]
`default_nettype none

module rrc_cfg
    import rrc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               wr_en,
    input  wire logic [INDEX_W-1:0] wr_index,
    input  wire logic [COORD_W-1:0] wr_data,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                REG_EDGE_LEFT:           cfg_next.edge_left   = wr_data;
                REG_EDGE_RIGHT:          cfg_next.edge_right  = wr_data;
                REG_EDGE_BOTTOM:         cfg_next.edge_bottom = wr_data;
                REG_EDGE_TOP:            cfg_next.edge_top    = wr_data;
                REG_RADIUS_RIGHT_BOTTOM: cfg_next.radius[CORNER_RB] = wr_data[RADIUS_W-1:0];
                REG_RADIUS_RIGHT_TOP:    cfg_next.radius[CORNER_RT] = wr_data[RADIUS_W-1:0];
                REG_RADIUS_LEFT_TOP:     cfg_next.radius[CORNER_LT] = wr_data[RADIUS_W-1:0];
                REG_RADIUS_LEFT_BOTTOM:  cfg_next.radius[CORNER_LB] = wr_data[RADIUS_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.edge_left   <= EDGE_LEFT_RESET;
            cfg_reg.edge_right  <= EDGE_RIGHT_RESET;
            cfg_reg.edge_bottom <= EDGE_BOTTOM_RESET;
            cfg_reg.edge_top    <= EDGE_TOP_RESET;
            cfg_reg.radius      <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[src/rrc_front.sv]
`default_nettype none

module rrc_front
    import rrc_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic signed [COORD_W-1:0] point_x,
    input  wire logic signed [COORD_W-1:0] point_y,
    input  wire cfg_t                      cfg,
    output corner_t                        corner
);

    // Stage 0: captured point.
    logic                      v0_reg;
    logic signed [COORD_W-1:0] x0_reg;
    logic signed [COORD_W-1:0] y0_reg;

    // Stage 1: edge test and clamped radii, all at twice the input scale.
    logic                                  v1_reg;
    logic                                  inside1_reg;
    logic                                  zero1_reg;
    logic signed [GEO_W-1:0]               px1_reg;
    logic signed [GEO_W-1:0]               py1_reg;
    logic signed [CORNERS-1:0][GEO_W-1:0]  rc1_reg;

    corner_t corner_reg;
    corner_t corner_next;

    logic signed [COORD_W-1:0] el, er, eb, et;
    logic                      inside1_next;
    logic                      zero1_next;
    logic signed [COORD_W:0]   span_w, span_h, min_span;
    logic signed [GEO_W-1:0]   min_span_g;
    logic signed [CORNERS-1:0][GEO_W-1:0] rc1_next;
    logic signed [GEO_W-1:0]   rad2;

    logic signed [GEO_W-1:0]   l2, rt2, b2, t2;
    logic signed [GEO_W-1:0]   cx_rb, cy_rb, cx_rt, cy_rt, cx_lt, cy_lt, cx_lb, cy_lb;
    logic                      in_rb, in_rt, in_lt, in_lb;

    always_comb begin
        el = cfg.edge_left;
        er = cfg.edge_right;
        eb = cfg.edge_bottom;
        et = cfg.edge_top;

        inside1_next = (x0_reg >= el) && (x0_reg <= er) && (y0_reg >= eb) && (y0_reg <= et);
        zero1_next   = (cfg.radius == '0);

        span_w   = (COORD_W+1)'(er) - (COORD_W+1)'(el);
        span_h   = (COORD_W+1)'(et) - (COORD_W+1)'(eb);
        min_span = (span_w < span_h) ? span_w : span_h;
        min_span_g = GEO_W'(min_span);

        rad2 = '0;
        for (int i = 0; i < CORNERS; i++) begin
            rad2 = signed'({{(GEO_W-RADIUS_W-1){1'b0}}, cfg.radius[i], 1'b0});
            rc1_next[i] = (rad2 < min_span_g) ? rad2 : min_span_g;
        end
    end

    always_comb begin
        l2  = GEO_W'(el) <<< 1;
        rt2 = GEO_W'(er) <<< 1;
        b2  = GEO_W'(eb) <<< 1;
        t2  = GEO_W'(et) <<< 1;

        cx_rb = rt2 - rc1_reg[CORNER_RB];
        cy_rb = b2  + rc1_reg[CORNER_RB];
        cx_rt = rt2 - rc1_reg[CORNER_RT];
        cy_rt = t2  - rc1_reg[CORNER_RT];
        cx_lt = l2  + rc1_reg[CORNER_LT];
        cy_lt = t2  - rc1_reg[CORNER_LT];
        cx_lb = l2  + rc1_reg[CORNER_LB];
        cy_lb = b2  + rc1_reg[CORNER_LB];

        in_rb = (px1_reg > cx_rb) && (py1_reg < cy_rb);
        in_rt = (px1_reg > cx_rt) && (py1_reg > cy_rt);
        in_lt = (px1_reg < cx_lt) && (py1_reg > cy_lt);
        in_lb = (px1_reg < cx_lb) && (py1_reg < cy_lb);

        corner_next.valid       = v1_reg;
        corner_next.outside     = !inside1_reg;
        corner_next.skip_circle = zero1_reg || !(in_rb || in_rt || in_lt || in_lb);
        if (in_rb) begin
            corner_next.dx = px1_reg - cx_rb;
            corner_next.dy = py1_reg - cy_rb;
            corner_next.r  = rc1_reg[CORNER_RB];
        end else if (in_rt) begin
            corner_next.dx = px1_reg - cx_rt;
            corner_next.dy = py1_reg - cy_rt;
            corner_next.r  = rc1_reg[CORNER_RT];
        end else if (in_lt) begin
            corner_next.dx = px1_reg - cx_lt;
            corner_next.dy = py1_reg - cy_lt;
            corner_next.r  = rc1_reg[CORNER_LT];
        end else begin
            corner_next.dx = px1_reg - cx_lb;
            corner_next.dy = py1_reg - cy_lb;
            corner_next.r  = rc1_reg[CORNER_LB];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg           <= 1'b0;
            v1_reg           <= 1'b0;
            corner_reg.valid <= 1'b0;
        end else if (en) begin
            v0_reg      <= in_valid;
            v1_reg      <= v0_reg;
            x0_reg      <= point_x;
            y0_reg      <= point_y;
            inside1_reg <= inside1_next;
            zero1_reg   <= zero1_next;
            px1_reg     <= GEO_W'(x0_reg) <<< 1;
            py1_reg     <= GEO_W'(y0_reg) <<< 1;
            rc1_reg     <= rc1_next;
            corner_reg  <= corner_next;
        end
    end

    assign corner = corner_reg;

endmodule

`default_nettype wire

[src/rrc_back.sv]
`default_nettype none

module rrc_back
    import rrc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    en,
    input  wire corner_t corner,
    output logic         out_valid,
    output logic         out_visible
);

    logic                   v3_reg;
    logic                   outside3_reg;
    logic                   skip3_reg;
    logic signed [SQ_W-1:0] dx2_reg;
    logic signed [SQ_W-1:0] dy2_reg;
    logic signed [SQ_W-1:0] r2_reg;

    logic                   v4_reg;
    logic                   visible4_reg;
    logic                   visible4_next;
    logic signed [SUM_W-1:0] dist_sq;

    always_comb begin
        dist_sq = SUM_W'(dx2_reg) + SUM_W'(dy2_reg);
        if (outside3_reg) begin
            visible4_next = 1'b0;
        end else if (skip3_reg) begin
            visible4_next = 1'b1;
        end else begin
            visible4_next = !(dist_sq > SUM_W'(r2_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= corner.valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            outside3_reg <= corner.outside;
            skip3_reg    <= corner.skip_circle;
            dx2_reg      <= corner.dx * corner.dx;
            dy2_reg      <= corner.dy * corner.dy;
            r2_reg       <= corner.r * corner.r;
            visible4_reg <= visible4_next;
        end
    end

    assign out_valid   = v4_reg;
    assign out_visible = visible4_reg;

endmodule

`default_nettype wire

[src/rounded_rect_clip_test.sv]
// Throughput: one point per cycle; the five stages advance together, held while a
// finished result waits to be taken.
// Reset (aresetn low at a clock edge) empties the pipeline and restores the edge and
// radius registers to their default values.
`default_nettype none

module rounded_rect_clip_test
    import rrc_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic signed [COORD_W-1:0] s_point_x,
    input  wire logic signed [COORD_W-1:0] s_point_y,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_visible,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [INDEX_W-1:0]        cfg_index,
    input  wire logic [COORD_W-1:0]        cfg_data
);

    cfg_t    cfg;
    corner_t corner;
    logic    en;

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    rrc_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    rrc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .point_x  (s_point_x),
        .point_y  (s_point_y),
        .cfg      (cfg),
        .corner   (corner)
    );

    rrc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .corner      (corner),
        .out_valid   (m_valid),
        .out_visible (m_visible)
    );

endmodule

`default_nettype wire

[src/rrc_checker.sv]
`default_nettype none

module rrc_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_visible,
    input wire logic cfg_ready
);

    // A pending result must hold until its transaction completes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_visible))
        else $error("result changed while stalled");

    // After reset no result is pending.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // The input side is stalled exactly when a finished result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output slot");

    // The register port never stalls.
    assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("configuration port not ready");

endmodule

bind rounded_rect_clip_test rrc_checker u_rrc_checker (.*);

`default_nettype wire

[tb/rounded_rect_clip_test_test.sv]
module rounded_rect_clip_test_test;
    import rrc_pkg::*;

    localparam longint COORD_MIN = -8388608;
    localparam longint COORD_MAX = 8388607;
    localparam longint RADIUS_MAX = 8388607;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SHAPE_COUNT = 6;
    localparam int RANDOM_PHASES = 12;
    localparam int POINTS_PER_PHASE = 48;

    typedef enum int {
        SHAPE_BOX,
        SHAPE_FULL_FIELD,
        SHAPE_INVERTED,
        SHAPE_SQUARE,
        SHAPE_SLIVER,
        SHAPE_RAW
    } shape_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      visible;
    } hit_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_point_x = '0;
    logic signed [COORD_W-1:0] s_point_y = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_visible;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [INDEX_W-1:0]        cfg_index = REG_EDGE_LEFT;
    logic [COORD_W-1:0]        cfg_data = '0;

    cfg_t clip_regs;
    hit_t visibility_due[$];
    hit_t due;
    int   errors = 0;
    int   quiet_cycles = 0;
    int   stall_left = 0;
    bit   bursts_on = 1'b0;

    rounded_rect_clip_test u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_point_x (s_point_x),
        .s_point_y (s_point_y),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_visible (m_visible),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    function automatic longint rand_between(input longint lo, input longint hi);
        return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endfunction

    function automatic longint fit_coord(input longint v);
        if (v < COORD_MIN) begin
            return COORD_MIN;
        end
        if (v > COORD_MAX) begin
            return COORD_MAX;
        end
        return v;
    endfunction

    function automatic logic within_radius(input longint px, input longint py,
                                           input longint cx, input longint cy,
                                           input longint r);
        return (px - cx) * (px - cx) + (py - cy) * (py - cy) <= r * r;
    endfunction

    // Geometry is doubled so that half sizes and clamped radii stay exact.
    function automatic logic point_visible(input logic signed [COORD_W-1:0] x_in,
                                           input logic signed [COORD_W-1:0] y_in);
        longint x, y, l, r, b, t, span, px, py;
        longint rad [CORNERS];
        int c;
        x = x_in;
        y = y_in;
        l = $signed(clip_regs.edge_left);
        r = $signed(clip_regs.edge_right);
        b = $signed(clip_regs.edge_bottom);
        t = $signed(clip_regs.edge_top);
        if (x < l || x > r || y < b || y > t) begin
            return 1'b0;
        end
        if (clip_regs.radius == '0) begin
            return 1'b1;
        end
        span = (r - l < t - b) ? r - l : t - b;
        for (c = 0; c < CORNERS; c++) begin
            rad[c] = 2 * longint'(clip_regs.radius[c]);
            if (rad[c] > span) begin
                rad[c] = span;
            end
        end
        px = 2 * x;
        py = 2 * y;
        l = 2 * l;
        r = 2 * r;
        b = 2 * b;
        t = 2 * t;
        if (px > r - rad[CORNER_RB] && py < b + rad[CORNER_RB]) begin
            return within_radius(px, py, r - rad[CORNER_RB], b + rad[CORNER_RB], rad[CORNER_RB]);
        end
        if (px > r - rad[CORNER_RT] && py > t - rad[CORNER_RT]) begin
            return within_radius(px, py, r - rad[CORNER_RT], t - rad[CORNER_RT], rad[CORNER_RT]);
        end
        if (px < l + rad[CORNER_LT] && py > t - rad[CORNER_LT]) begin
            return within_radius(px, py, l + rad[CORNER_LT], t - rad[CORNER_LT], rad[CORNER_LT]);
        end
        if (px < l + rad[CORNER_LB] && py < b + rad[CORNER_LB]) begin
            return within_radius(px, py, l + rad[CORNER_LB], b + rad[CORNER_LB], rad[CORNER_LB]);
        end
        return 1'b1;
    endfunction

    function automatic void apply_reg(input logic [INDEX_W-1:0] index,
                                      input logic [COORD_W-1:0] data);
        case (index)
            REG_EDGE_LEFT:           clip_regs.edge_left = data;
            REG_EDGE_RIGHT:          clip_regs.edge_right = data;
            REG_EDGE_BOTTOM:         clip_regs.edge_bottom = data;
            REG_EDGE_TOP:            clip_regs.edge_top = data;
            REG_RADIUS_RIGHT_BOTTOM: clip_regs.radius[CORNER_RB] = data[RADIUS_W-1:0];
            REG_RADIUS_RIGHT_TOP:    clip_regs.radius[CORNER_RT] = data[RADIUS_W-1:0];
            REG_RADIUS_LEFT_TOP:     clip_regs.radius[CORNER_LT] = data[RADIUS_W-1:0];
            REG_RADIUS_LEFT_BOTTOM:  clip_regs.radius[CORNER_LB] = data[RADIUS_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [COORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(index, data);
    endtask

    task automatic program_clip(input logic [COORD_W-1:0] left, input logic [COORD_W-1:0] right,
                                input logic [COORD_W-1:0] bottom, input logic [COORD_W-1:0] top,
                                input logic [COORD_W-1:0] rb, input logic [COORD_W-1:0] rt,
                                input logic [COORD_W-1:0] lt, input logic [COORD_W-1:0] lb);
        write_reg(REG_EDGE_LEFT, left);
        write_reg(REG_EDGE_RIGHT, right);
        write_reg(REG_EDGE_BOTTOM, bottom);
        write_reg(REG_EDGE_TOP, top);
        write_reg(REG_RADIUS_RIGHT_BOTTOM, rb);
        write_reg(REG_RADIUS_RIGHT_TOP, rt);
        write_reg(REG_RADIUS_LEFT_TOP, lt);
        write_reg(REG_RADIUS_LEFT_BOTTOM, lb);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_point(input longint x, input longint y);
        hit_t item;
        if (bursts_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_point_x <= x[COORD_W-1:0];
        s_point_y <= y[COORD_W-1:0];
        do @(posedge aclk); while (!s_ready);
        item.x = x[COORD_W-1:0];
        item.y = y[COORD_W-1:0];
        item.visible = point_visible(item.x, item.y);
        visibility_due.push_back(item);
    endtask

    task automatic settle_pipeline();
        s_valid <= 1'b0;
        do @(posedge aclk); while (visibility_due.size() != 0);
    endtask

    task automatic send_random_point();
        longint lo_x, hi_x, lo_y, hi_y, mx, my, x, y;
        lo_x = $signed(clip_regs.edge_left);
        hi_x = $signed(clip_regs.edge_right);
        lo_y = $signed(clip_regs.edge_bottom);
        hi_y = $signed(clip_regs.edge_top);
        if (lo_x > hi_x) begin
            x = lo_x;
            lo_x = hi_x;
            hi_x = x;
        end
        if (lo_y > hi_y) begin
            y = lo_y;
            lo_y = hi_y;
            hi_y = y;
        end
        if ($urandom_range(0, 4) == 0) begin
            x = rand_between(COORD_MIN, COORD_MAX);
            y = rand_between(COORD_MIN, COORD_MAX);
        end else begin
            mx = (hi_x - lo_x) / 8 + 4;
            my = (hi_y - lo_y) / 8 + 4;
            x = fit_coord(rand_between(lo_x - mx, hi_x + mx));
            y = fit_coord(rand_between(lo_y - my, hi_y + my));
        end
        send_point(x, y);
    endtask

    task automatic program_random_shape(input shape_t shape);
        longint cx, cy, hw, hh, left, right, bottom, top, swap;
        logic [COORD_W-1:0] rad [CORNERS];
        int c;
        cx = rand_between(-(1 << 20), 1 << 20);
        cy = rand_between(-(1 << 20), 1 << 20);
        hw = rand_between(1, 1 << 16);
        hh = rand_between(1, 1 << 16);
        if (shape == SHAPE_SLIVER) begin
            hw = rand_between(0, 3);
            hh = rand_between(0, 1 << 10);
        end
        left = cx - hw;
        right = cx + hw;
        bottom = cy - hh;
        top = cy + hh;
        for (c = 0; c < CORNERS; c++) begin
            case ($urandom_range(0, 3))
                0: rad[c] = '0;
                1: rad[c] = COORD_W'(rand_between(0, hw));
                2: rad[c] = COORD_W'(rand_between(0, hw + hh));
                default: rad[c] = COORD_W'($urandom);
            endcase
            rad[c][COORD_W-1] = 1'($urandom_range(0, 1));
            if (shape == SHAPE_SQUARE) begin
                rad[c][RADIUS_W-1:0] = '0;
            end
        end
        case (shape)
            SHAPE_FULL_FIELD: begin
                left = COORD_MIN;
                right = COORD_MAX;
                bottom = COORD_MIN;
                top = COORD_MAX;
            end
            SHAPE_INVERTED: begin
                if ($urandom_range(0, 1) == 1) begin
                    swap = left;
                    left = right;
                    right = swap;
                end else begin
                    swap = bottom;
                    bottom = top;
                    top = swap;
                end
            end
            SHAPE_RAW: begin
                left = rand_between(COORD_MIN, COORD_MAX);
                right = rand_between(COORD_MIN, COORD_MAX);
                bottom = rand_between(COORD_MIN, COORD_MAX);
                top = rand_between(COORD_MIN, COORD_MAX);
            end
            default: ;
        endcase
        program_clip(left[COORD_W-1:0], right[COORD_W-1:0], bottom[COORD_W-1:0], top[COORD_W-1:0],
                     rad[CORNER_RB], rad[CORNER_RT], rad[CORNER_LT], rad[CORNER_LB]);
    endtask

    task automatic test_plain_edges();
        send_point(0, 0);
        send_point(-25600, -25600);
        send_point(25600, 25600);
        send_point(25601, 0);
        send_point(0, -25601);
        send_point(COORD_MIN, COORD_MIN);
        send_point(COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MAX);
        settle_pipeline();
    endtask

    // The left-top radius exceeds the half size and is clamped; the left-bottom
    // write carries a stray top bit that the radius register drops.
    task automatic test_rounded_corners();
        program_clip(-24'sd25600, 24'sd25600, -24'sd25600, 24'sd25600,
                     24'd2560, 24'd5120, RADIUS_MAX[COORD_W-1:0], 24'h800500);
        send_point(25600, -25600);
        send_point(24576, -25088);
        send_point(24577, -25088);
        send_point(25600, -23040);
        send_point(25600, 25600);
        send_point(23552, 24576);
        send_point(-25600, 25600);
        send_point(-15360, 20480);
        send_point(-25600, -25600);
        send_point(0, 0);
        settle_pipeline();
    endtask

    task automatic test_degenerate_boxes();
        program_clip(24'sd1000, -24'sd1000, -24'sd100, 24'sd100,
                     24'd256, 24'd256, 24'd256, 24'd256);
        send_point(0, 0);
        send_point(1000, 0);
        send_point(-1000, 0);
        settle_pipeline();
        program_clip(COORD_MIN[COORD_W-1:0], COORD_MAX[COORD_W-1:0],
                     COORD_MIN[COORD_W-1:0], COORD_MAX[COORD_W-1:0],
                     24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_point(0, 0);
        send_point(COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN);
        send_point(COORD_MIN, 0);
        settle_pipeline();
    endtask

    task automatic test_random_shapes();
        int phase;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            bursts_on = (phase < RANDOM_PHASES - 3) && (phase % 4 != 2);
            program_random_shape(shape_t'(phase % SHAPE_COUNT));
            repeat (POINTS_PER_PHASE) send_random_point();
            settle_pipeline();
        end
    endtask

    always @(posedge aclk) begin
        if (bursts_on && stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (bursts_on && $urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_ready <= 1'b1;
            stall_left <= 0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (visibility_due.size() == 0) begin
                report_mismatch("result transaction with no point outstanding");
            end else begin
                due = visibility_due.pop_front();
                if (m_visible !== due.visible) begin
                    report_mismatch($sformatf("point (%0d, %0d): visible %b, predicted %b",
                                              due.x, due.y, m_visible, due.visible));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("rounded_rect_clip_test_test failed");
            $finish;
        end
    end

    initial begin
        clip_regs.edge_left = EDGE_LEFT_RESET;
        clip_regs.edge_right = EDGE_RIGHT_RESET;
        clip_regs.edge_bottom = EDGE_BOTTOM_RESET;
        clip_regs.edge_top = EDGE_TOP_RESET;
        clip_regs.radius = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        bursts_on = 1'b1;
        test_plain_edges();
        test_rounded_corners();
        test_degenerate_boxes();
        test_random_shapes();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("rounded_rect_clip_test_test passed");
        end else begin
            $display("rounded_rect_clip_test_test failed");
        end
        $finish;
    end

endmodule

[sim.f]
src/rrc_pkg.sv
src/rrc_cfg.sv
src/rrc_front.sv
src/rrc_back.sv
src/rounded_rect_clip_test.sv
src/rrc_checker.sv
tb/rounded_rect_clip_test_test.sv
